### rtl/core/slab_pkg.sv
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared types and codes for the slab block allocator.
// ----------------------------------------------------------------------------
package slab_pkg;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusNoPage = 2'd1,
    StatusBadFree = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TagNone    = 2'd0,
    TagPartial = 2'd1,
    TagFull    = 2'd2
  } tag_e;

  typedef enum logic [0:0] {
    ModeAlloc = 1'b0,
    ModeFree  = 1'b1
  } mode_e;

  localparam logic [0:0] CfgBlocksPerPage = 1'b0;
  localparam logic [0:0] CfgPageLimit     = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StAllocRd,
    StAllocTake,
    StRefill,
    StScan,
    StTakeRd,
    StTake2,
    StFreeRd,
    StFreeDo,
    StOut
  } state_e;

endpackage

### rtl/core/slab_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module slab_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/core/slab_block_allocator.sv
// ----------------------------------------------------------------------------
// Slab block allocator
// Hands out and takes back blocks over a fixed pool of page slots.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tdata holds mode, page_index and
// block_index. mode 0 allocates a block, mode 1 frees the given block. Each
// request gives one result on m_axis: status, granted page, granted block and
// the number of page slots held. Configuration (blocks per page, page limit)
// is written on the cfg channel while the block is idle.
// A request is worked by a small sequencer around one shared adder/compare
// unit and the free-stack RAM. A free reads the page and then pushes the
// block back. An allocation tries the active page; on failure it pops a page
// from the partial list or, when that list is empty, scans for the lowest
// unused slot, one slot per cycle, and then takes a block from that page.
// s_axis_tready is low while a request is in work. The result waits in the
// output register until taken; a stalled receiver holds the block there.
// Reset clears all page bookkeeping at once; the free-stack RAM and the list
// links need no clearing.
// ----------------------------------------------------------------------------
module slab_block_allocator #(
  parameter int NUM_PAGES  = 16,
  parameter int MAX_BLOCKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] mode, [4:1] page_index, [10:5] block_index, [15:11] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [5:2] granted_page, [11:6] granted_block,
  // [16:12] pages_held, [23:17] zero
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  import slab_pkg::*;

  localparam int PW = $clog2(NUM_PAGES + 1);     // page id incl. null
  localparam int PI = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);    // counts 0..MAX_BLOCKS
  localparam int BI = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SD = NUM_PAGES * MAX_BLOCKS;
  localparam int SA = $clog2(SD) > 0 ? $clog2(SD) : 1;
  localparam logic [PW-1:0] Nil = PW'(NUM_PAGES);

  state_e state_q, state_d;

  logic [6:0] bpp_q;
  logic [4:0] lim_q;

  logic           used_q  [NUM_PAGES];
  logic [CW-1:0]  live_q  [NUM_PAGES];
  logic [CW-1:0]  fresh_q [NUM_PAGES];
  tag_e           tag_q   [NUM_PAGES];
  logic [PW-1:0]  pnext_q [NUM_PAGES];
  logic [PW-1:0]  pprev_q [NUM_PAGES];
  logic [PW-1:0]  head_q, cur_q, total_q;

  logic [3:0]     pg_q;
  logic [5:0]     bk_q;
  logic [PW-1:0]  scan_q;
  logic [1:0]     st_q;
  logic [3:0]     gp_q;
  logic [5:0]     gb_q;

  // effective limits
  logic [CW-1:0] eff_b;
  logic [PW-1:0] eff_l;
  always_comb begin
    if (bpp_q == 7'd0) eff_b = CW'(1);
    else if ({25'd0, bpp_q} > 32'(MAX_BLOCKS)) eff_b = CW'(MAX_BLOCKS);
    else eff_b = CW'(bpp_q);
    if ({27'd0, lim_q} > 32'(NUM_PAGES)) eff_l = Nil;
    else eff_l = PW'(lim_q);
  end

  // shared arithmetic: one adder and one compare on the selected page
  logic [PI-1:0] sel;
  logic [CW-1:0] s_live, s_fresh, diff;
  logic          gt;
  logic          take_ok;
  logic          pg_bad;
  always_comb begin
    sel = (state_q == StFreeRd || state_q == StFreeDo) ? PI'(pg_q) : PI'(cur_q);
    s_live  = live_q[sel];
    s_fresh = fresh_q[sel];
    diff = s_fresh - s_live;
    gt   = s_fresh > s_live;
    take_ok = (cur_q != Nil) && (gt || s_fresh < eff_b);
    pg_bad  = 32'(pg_q) >= 32'(NUM_PAGES);
  end

  // free stack RAM
  logic          ram_we;
  logic [SA-1:0] ram_wa, ram_ra;
  logic [BI-1:0] ram_rd;
  logic [CW-1:0] pos_rd;
  always_comb begin
    pos_rd = diff - CW'(1);
    if (32'(pos_rd) >= 32'(MAX_BLOCKS)) pos_rd = CW'(MAX_BLOCKS - 1);
    ram_ra = SA'(32'(sel) * MAX_BLOCKS + 32'(pos_rd));
    ram_wa = SA'(32'(sel) * MAX_BLOCKS + 32'(diff));
    ram_we = (state_q == StFreeDo) && !pg_bad && used_q[sel] &&
             (CW'(bk_q) < s_fresh) && (s_live != '0) && (32'(diff) < 32'(MAX_BLOCKS));
  end

  slab_ram #(.Width(BI), .Depth(SD)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (BI'(bk_q)),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {7'd0, 5'(total_q), gb_q, gp_q, st_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:      if (s_axis_tvalid) begin
        state_d = (s_axis_tdata[0] == ModeFree) ? StFreeRd : StAllocRd;
      end
      StAllocRd:   state_d = StAllocTake;
      StAllocTake: state_d = take_ok ? StOut : StRefill;
      StRefill:    state_d = (head_q != Nil) ? StTakeRd : StScan;
      StScan:      if (scan_q >= eff_l || !used_q[PI'(scan_q)]) state_d = StTakeRd;
      StTakeRd:    state_d = StTake2;
      StTake2:     state_d = StOut;
      StFreeRd:    state_d = StFreeDo;
      StFreeDo:    state_d = StOut;
      StOut:       if (m_axis_tready) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  // page bookkeeping and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bpp_q   <= 7'd64;
      lim_q   <= 5'd16;
      head_q  <= Nil;
      cur_q   <= Nil;
      total_q <= '0;
      scan_q  <= '0;
      for (int i = 0; i < NUM_PAGES; i++) begin
        used_q[i]  <= 1'b0;
        live_q[i]  <= '0;
        fresh_q[i] <= '0;
        tag_q[i]   <= TagNone;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgBlocksPerPage) bpp_q <= cfg_data_i;
        else lim_q <= cfg_data_i[4:0];
      end
      case (state_q)
        StIdle: if (s_axis_tvalid) begin
          pg_q   <= s_axis_tdata[4:1];
          bk_q   <= s_axis_tdata[10:5];
          st_q   <= StatusOk;
          gp_q   <= '0;
          gb_q   <= '0;
        end
        // try the active page; on failure go to refill (AllocTake) or report no page (Take2)
        StAllocTake, StTake2: begin
          if (cur_q != Nil && gt) begin
            live_q[sel] <= s_live + CW'(1);
            gp_q <= 4'(cur_q);
            gb_q <= 6'(ram_rd);
          end else if (cur_q != Nil && s_fresh < eff_b) begin
            fresh_q[sel] <= s_fresh + CW'(1);
            live_q[sel]  <= s_live + CW'(1);
            gp_q <= 4'(cur_q);
            gb_q <= 6'(s_fresh);
          end else if (state_q == StAllocTake) begin
            if (cur_q != Nil) tag_q[sel] <= TagFull;
            cur_q   <= Nil;
            scan_q  <= '0;
          end else begin
            st_q <= StatusNoPage;
          end
        end
        // pop the partial head into the active slot
        StRefill: if (head_q != Nil) begin
          cur_q <= head_q;
          tag_q[PI'(head_q)] <= TagNone;
          head_q <= pnext_q[PI'(head_q)];
          if (pnext_q[PI'(head_q)] != Nil) pprev_q[PI'(pnext_q[PI'(head_q)])] <= Nil;
        end
        // look for the lowest unused slot, one per cycle
        StScan: begin
          if (scan_q < eff_l) begin
            if (!used_q[PI'(scan_q)]) begin
              used_q[PI'(scan_q)]  <= 1'b1;
              live_q[PI'(scan_q)]  <= '0;
              fresh_q[PI'(scan_q)] <= '0;
              tag_q[PI'(scan_q)]   <= TagNone;
              total_q <= total_q + PW'(1);
              cur_q   <= scan_q;
            end else begin
              scan_q <= scan_q + PW'(1);
            end
          end
        end
        // flag a bad free, else push the block back and fix up the lists
        StFreeDo: begin
          if (pg_bad || !used_q[sel]) begin
            st_q <= StatusBadFree;
          end else if (CW'(bk_q) < s_fresh && s_live != '0) begin
            live_q[sel] <= s_live - CW'(1);
            if (PW'(pg_q) != cur_q) begin
              if (s_live == CW'(1)) begin
                if (tag_q[sel] == TagPartial) begin
                  if (pprev_q[sel] != Nil) pnext_q[PI'(pprev_q[sel])] <= pnext_q[sel];
                  else head_q <= pnext_q[sel];
                  if (pnext_q[sel] != Nil) pprev_q[PI'(pnext_q[sel])] <= pprev_q[sel];
                end
                used_q[sel]  <= 1'b0;
                tag_q[sel]   <= TagNone;
                fresh_q[sel] <= '0;
                if (total_q != '0) total_q <= total_q - PW'(1);
              end else if (tag_q[sel] == TagFull) begin
                pnext_q[sel] <= head_q;
                pprev_q[sel] <= Nil;
                if (head_q != Nil) pprev_q[PI'(head_q)] <= PW'(pg_q);
                head_q <= PW'(pg_q);
                tag_q[sel] <= TagPartial;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // the result register holds while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // no request is taken while a result is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready during output");
  // pages held never exceeds the pool
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= Nil) else $error("page count overflow");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Slab block allocator testbench
// Drives allocate and free requests in bursts, predicts every result from an
// in-bench model of the page pool and checks each result field by field,
// across several block-count and page-limit settings.
// ----------------------------------------------------------------------------
module tb_top;
  import slab_pkg::*;

  localparam int NPG = 16;
  localparam int NBLK = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;

  slab_block_allocator i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Pool model
  logic [6:0] blk_cfg = 7'd64;
  logic [4:0] lim_cfg = 5'd16;
  logic       used [NPG];
  int         live [NPG];
  int         fresh [NPG];
  tag_e       tag [NPG];
  int         nxt [NPG];
  int         prv [NPG];
  int         head = NPG;
  int         cur = NPG;
  int         total = 0;
  logic [5:0] stk [NPG][NBLK];

  logic [15:0] req_q[$];
  logic [23:0] result_q[$];
  logic [9:0]  granted_q[$];
  int          errors = 0;
  int          hold_seq = 0;

  initial begin
    for (int p = 0; p < NPG; p++) begin
      used[p] = 1'b0; live[p] = 0; fresh[p] = 0; tag[p] = TagNone;
      nxt[p] = 0; prv[p] = 0;
      for (int b = 0; b < NBLK; b++) stk[p][b] = '0;
    end
  end

  function automatic int eff_blocks();
    if (blk_cfg == 0) return 1;
    if (blk_cfg > NBLK) return NBLK;
    return blk_cfg;
  endfunction

  function automatic void link_head(int p);
    nxt[p] = head;
    prv[p] = NPG;
    if (head < NPG) prv[head] = p;
    head = p;
    tag[p] = TagPartial;
  endfunction

  function automatic void unlink(int p);
    if (prv[p] < NPG) nxt[prv[p]] = nxt[p]; else head = nxt[p];
    if (nxt[p] < NPG) prv[nxt[p]] = prv[p];
    tag[p] = TagNone;
  endfunction

  function automatic logic take_block(int p, output logic [5:0] b);
    int pos;
    b = '0;
    if (fresh[p] > live[p]) begin
      pos = fresh[p] - live[p] - 1;
      if (pos >= NBLK) pos = NBLK - 1;
      b = stk[p][pos];
      live[p]++;
      return 1'b1;
    end
    if (fresh[p] < eff_blocks()) begin
      b = fresh[p][5:0];
      fresh[p]++;
      live[p]++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the pool model by one request and give the expected result
  function automatic logic [23:0] serve_request(logic [15:0] req);
    mode_e      md;
    int         pg, bk, lim, p;
    status_e    st;
    logic [3:0] gp;
    logic [5:0] gb, blk;
    logic       ok, was_full;
    md = mode_e'(req[0]);
    pg = req[4:1];
    bk = req[10:5];
    st = StatusOk; gp = '0; gb = '0; blk = '0; ok = 1'b0;
    if (md == ModeAlloc) begin
      if (cur < NPG) ok = take_block(cur, blk);
      if (!ok) begin
        if (cur < NPG) tag[cur] = TagFull;
        cur = NPG;
        if (head < NPG) begin
          p = head;
          unlink(p);
          cur = p;
        end else begin
          lim = (lim_cfg < NPG) ? lim_cfg : NPG;
          for (int s = 0; s < lim; s++) begin
            if (!used[s]) begin
              used[s] = 1'b1; live[s] = 0; fresh[s] = 0; tag[s] = TagNone;
              total++;
              cur = s;
              break;
            end
          end
        end
        if (cur < NPG) ok = take_block(cur, blk);
      end
      if (ok) begin
        gp = cur[3:0];
        gb = blk;
        granted_q.push_back({gp, gb});
      end else begin
        st = StatusNoPage;
      end
    end else if (!used[pg]) begin
      st = StatusBadFree;
    end else if (bk < fresh[pg] && live[pg] > 0) begin
      was_full = (tag[pg] == TagFull);
      if (fresh[pg] - live[pg] < NBLK) stk[pg][fresh[pg] - live[pg]] = bk[5:0];
      live[pg]--;
      if (pg != cur) begin
        if (live[pg] == 0) begin
          if (tag[pg] == TagPartial) unlink(pg);
          used[pg] = 1'b0; tag[pg] = TagNone; live[pg] = 0; fresh[pg] = 0;
          if (total > 0) total--;
        end else if (was_full) begin
          link_head(pg);
        end
      end
    end
    return {7'd0, total[4:0], gb, gp, st};
  endfunction

  task automatic report(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  // Driver: bursts and gaps; hold an offered transaction until taken
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      result_q.push_back(serve_request(s_axis_tdata));
      void'(req_q.pop_front());
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() > 0 && rst_ni) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req_q[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transaction and stall on a pattern
  int hold_left = 0;
  int hold_seen = 0;
  int stall_phase = 0;
  always @(posedge clk_i) begin
    logic [23:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[1:0] != want[1:0])
          report("status", 8'(m_axis_tdata[1:0]), 8'(want[1:0]));
        if (m_axis_tdata[5:2] != want[5:2])
          report("granted_page", 8'(m_axis_tdata[5:2]), 8'(want[5:2]));
        if (m_axis_tdata[11:6] != want[11:6])
          report("granted_block", 8'(m_axis_tdata[11:6]), 8'(want[11:6]));
        if (m_axis_tdata[16:12] != want[16:12])
          report("pages_held", 8'(m_axis_tdata[16:12]), 8'(want[16:12]));
        if (m_axis_tdata[23:17] != '0)
          report("padding", 8'(m_axis_tdata[23:17]), 8'd0);
      end
    end
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = 400;
    end
    stall_phase = (stall_phase + 1) % 97;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_phase < 40) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgBlocksPerPage) blk_cfg = val;
    else lim_cfg = val[4:0];
  endtask

  // Wait until all requests are served, then let the sequencer go quiet
  task automatic drain();
    while (req_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic void push_req(mode_e md, logic [3:0] pg, logic [5:0] bk);
    req_q.push_back({5'd0, bk, pg, md});
  endfunction

  // Queue requests in chunks so that frees can target blocks already granted
  task automatic random_run(int n, int free_pct);
    int k;
    logic [9:0] g;
    repeat (n / 8) begin
      repeat (8) begin
        if ($urandom_range(0, 99) < 12) begin
          req_q.push_back(16'($urandom_range(0, 16'h07ff)));
        end else if ($urandom_range(0, 99) < free_pct && granted_q.size() > 0) begin
          k = $urandom_range(0, granted_q.size() - 1);
          g = granted_q[k];
          granted_q.delete(k);
          push_req(ModeFree, g[9:6], g[5:0]);
        end else begin
          push_req(ModeAlloc, '0, '0);
        end
      end
      while (req_q.size() > 0) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: bad free, free of a block never handed out, extremes
    push_req(ModeFree, 4'd15, 6'd63);
    push_req(ModeAlloc, '0, '0);
    push_req(ModeFree, 4'd0, 6'd63);
    push_req(ModeAlloc, '0, '0);
    push_req(ModeFree, 4'd0, 6'd0);
    push_req(ModeAlloc, '0, '0);
    push_req(ModeFree, 4'd0, 6'd1);
    push_req(ModeFree, 4'd0, 6'd1);
    push_req(ModeFree, 4'd0, 6'd0);
    push_req(ModeFree, 4'd0, 6'd0);
    push_req(ModeAlloc, '0, '0);
    drain();
    // One block per page, limited pool: full pages, no page available
    write_reg(CfgBlocksPerPage, 7'd1);
    write_reg(CfgPageLimit, 5'd2);
    repeat (4) push_req(ModeAlloc, '0, '0);
    push_req(ModeFree, 4'd1, 6'd0);
    push_req(ModeFree, 4'd0, 6'd0);
    push_req(ModeAlloc, '0, '0);
    push_req(ModeAlloc, '0, '0);
    drain();
    granted_q.delete();
    write_reg(CfgPageLimit, 5'd0);
    push_req(ModeAlloc, '0, '0);
    push_req(ModeAlloc, '0, '0);
    drain();

    // Random phases over several settings
    write_reg(CfgBlocksPerPage, 7'd3);
    write_reg(CfgPageLimit, 5'd4);
    random_run(96, 45);
    drain();
    write_reg(CfgBlocksPerPage, 7'd127);
    write_reg(CfgPageLimit, 5'd31);
    hold_seq++;
    random_run(96, 30);
    drain();
    // Lower the block count with partial pages around: refills may fail
    write_reg(CfgBlocksPerPage, 7'd0);
    random_run(64, 50);
    drain();
    write_reg(CfgBlocksPerPage, 7'd2);
    write_reg(CfgPageLimit, 5'd16);
    random_run(96, 55);
    drain();
    write_reg(CfgBlocksPerPage, 7'd64);
    write_reg(CfgPageLimit, 5'd1);
    random_run(64, 40);
    drain();
    write_reg(CfgBlocksPerPage, 7'd5);
    write_reg(CfgPageLimit, 5'd16);
    random_run(136, 50);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
rtl/core/slab_pkg.sv
rtl/core/slab_ram.sv
rtl/core/slab_block_allocator.sv
tb/tb_top.sv
